// ----- src/sdd_pkg.sv -----
package sdd_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned LenWidth = 32;

  localparam logic [7:0] StartMark = 8'd2;
  localparam logic [7:0] EndMark = 8'd3;
  localparam logic [7:0] SelectedTypeReset = 8'd88;

  localparam logic [1:0] KIND_LEN = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TYPE = 2'd2;
  localparam logic [1:0] KIND_BODY = 2'd3;

  typedef enum logic [2:0] {
    PH_LEN0 = 3'd0,
    PH_LEN1 = 3'd1,
    PH_LEN2 = 3'd2,
    PH_LEN3 = 3'd3,
    PH_START = 3'd4,
    PH_TYPE = 3'd5,
    PH_BODY = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic is_selected;
    logic first_body;
    logic last_of_record;
    logic start_ok;
    logic end_ok;
    logic [CountWidth-1:0] record_count;
  } result_t;

  // Body length is the datagram length minus the start and type bytes,
  // clamped to zero when the difference is negative as a signed word.
  function automatic logic [LenWidth-1:0] body_len(input logic [LenWidth-1:0] len);
    logic [LenWidth-1:0] b;
    b = len - LenWidth'(2);
    return b[LenWidth-1] ? '0 : b;
  endfunction

endpackage

// ----- src/sdd_byte_if.sv -----
interface sdd_byte_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ----- src/sdd_label_if.sv -----
interface sdd_label_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic is_selected;
  logic first_body;
  logic last_of_record;
  logic start_ok;
  logic end_ok;
  logic [sdd_pkg::CountWidth-1:0] record_count;

  modport source (output valid, output out_byte, output byte_kind, output is_selected,
                  output first_body, output last_of_record, output start_ok,
                  output end_ok, output record_count, input ready);
  modport sink (input valid, input out_byte, input byte_kind, input is_selected,
                input first_body, input last_of_record, input start_ok,
                input end_ok, input record_count, output ready);
endinterface

// ----- src/sdd_in_reg.sv -----
module sdd_in_reg (
  input  logic clk,
  input  logic rst,
  sdd_byte_if.sink byte_in,
  input  logic take,
  output logic held_valid,
  output logic [7:0] held_byte
);

  // The held byte may be replaced in the same cycle it moves on.
  assign byte_in.ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_in.ready) begin
      held_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      held_byte <= byte_in.data_byte;
    end
  end

endmodule

// ----- src/sdd_core.sv -----
module sdd_core #(
  parameter int unsigned COUNT_BITS = sdd_pkg::CountBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  input  logic fire,
  input  logic [7:0] data_byte,
  output sdd_pkg::result_t res
);

  localparam int unsigned CW = sdd_pkg::CountWidth;
  localparam int unsigned LW = sdd_pkg::LenWidth;
  localparam logic [CW-1:0] CountLimit =
    (COUNT_BITS >= CW) ? {CW{1'b1}} : CW'((64'd1 << COUNT_BITS) - 64'd1);

  logic [7:0] selected_type;
  sdd_pkg::phase_t phase, phase_next;
  logic [LW-1:0] length_acc, length_acc_next;
  logic [LW-1:0] body_left, body_left_next;
  logic [7:0] current_type, current_type_next;
  logic start_good, start_good_next;
  logic end_good, end_good_next;
  logic [CW-1:0] selected_total, selected_total_next;
  logic [LW-1:0] body_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_type <= sdd_pkg::SelectedTypeReset;
    end else if (cfg_we) begin
      selected_type <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sdd_pkg::PH_LEN0;
      length_acc <= '0;
      body_left <= '0;
      current_type <= '0;
      start_good <= 1'b0;
      end_good <= 1'b0;
      selected_total <= '0;
    end else if (fire) begin
      phase <= phase_next;
      length_acc <= length_acc_next;
      body_left <= body_left_next;
      current_type <= current_type_next;
      start_good <= start_good_next;
      end_good <= end_good_next;
      selected_total <= selected_total_next;
    end
  end

  assign body_dec = (body_left != '0) ? body_left - LW'(1) : body_left;

  always_comb begin
    phase_next = phase;
    length_acc_next = length_acc;
    body_left_next = body_left;
    current_type_next = current_type;
    start_good_next = start_good;
    end_good_next = end_good;
    selected_total_next = selected_total;
    res = '0;
    res.out_byte = data_byte;

    case (phase)
      sdd_pkg::PH_LEN1: begin
        res.byte_kind = sdd_pkg::KIND_LEN;
        length_acc_next = length_acc | (LW'(data_byte) << 8);
        phase_next = sdd_pkg::PH_LEN2;
      end
      sdd_pkg::PH_LEN2: begin
        res.byte_kind = sdd_pkg::KIND_LEN;
        length_acc_next = length_acc | (LW'(data_byte) << 16);
        phase_next = sdd_pkg::PH_LEN3;
      end
      sdd_pkg::PH_LEN3: begin
        res.byte_kind = sdd_pkg::KIND_LEN;
        length_acc_next = length_acc | (LW'(data_byte) << 24);
        body_left_next = sdd_pkg::body_len(length_acc_next);
        phase_next = sdd_pkg::PH_START;
      end
      sdd_pkg::PH_START: begin
        res.byte_kind = sdd_pkg::KIND_START;
        start_good_next = (data_byte == sdd_pkg::StartMark);
        end_good_next = (body_left == LW'(1)) && (data_byte == sdd_pkg::EndMark);
        res.start_ok = start_good_next;
        phase_next = sdd_pkg::PH_TYPE;
      end
      sdd_pkg::PH_TYPE: begin
        res.byte_kind = sdd_pkg::KIND_TYPE;
        current_type_next = data_byte;
        res.start_ok = start_good;
        if (body_left == LW'(2)) begin
          end_good_next = (data_byte == sdd_pkg::EndMark);
        end
        if (data_byte == selected_type && selected_total < CountLimit) begin
          selected_total_next = selected_total + CW'(1);
        end
        if (body_left == '0) begin
          res.last_of_record = 1'b1;
          phase_next = sdd_pkg::PH_LEN0;
        end else begin
          phase_next = sdd_pkg::PH_BODY;
        end
      end
      sdd_pkg::PH_BODY: begin
        res.byte_kind = sdd_pkg::KIND_BODY;
        res.start_ok = start_good;
        res.first_body = (body_left == sdd_pkg::body_len(length_acc));
        body_left_next = body_dec;
        if (body_dec == LW'(2)) begin
          end_good_next = (data_byte == sdd_pkg::EndMark);
        end
        if (body_dec == '0) begin
          res.last_of_record = 1'b1;
          res.end_ok = end_good_next;
          phase_next = sdd_pkg::PH_LEN0;
        end else begin
          phase_next = sdd_pkg::PH_BODY;
        end
      end
      default: begin
        // First length byte; the unused phase code lands here as well.
        res.byte_kind = sdd_pkg::KIND_LEN;
        length_acc_next = LW'(data_byte);
        phase_next = sdd_pkg::PH_LEN1;
      end
    endcase

    if (res.byte_kind == sdd_pkg::KIND_TYPE || res.byte_kind == sdd_pkg::KIND_BODY) begin
      res.is_selected = (current_type_next == selected_type);
    end
    res.record_count = selected_total_next;
  end

endmodule

// ----- src/sdd_out_reg.sv -----
module sdd_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  input  sdd_pkg::result_t res,
  output logic can_take,
  sdd_label_if.source label_out
);

  logic out_valid;
  sdd_pkg::result_t held;

  assign can_take = !out_valid || label_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load_valid) begin
      held <= res;
    end
  end

  assign label_out.valid = out_valid;
  assign label_out.out_byte = held.out_byte;
  assign label_out.byte_kind = held.byte_kind;
  assign label_out.is_selected = held.is_selected;
  assign label_out.first_body = held.first_body;
  assign label_out.last_of_record = held.last_of_record;
  assign label_out.start_ok = held.start_ok;
  assign label_out.end_ok = held.end_ok;
  assign label_out.record_count = held.record_count;

endmodule

// ----- src/sonar_datagram_deframer_top.sv -----
// A byte accepted from the source is held in the input register, labelled, and loaded into
// the result register, from which the label is offered to the sink.
// Throughput: one byte per cycle, sustained, as long as the result side keeps taking requests.
// The rate is set by the pass through the labelling logic between the input register and
// the result register; both register stages stall together on back-pressure.
// Reset (rst, synchronous, active high) empties both stages, returns the parser to the first
// length byte, clears the selected-datagram count and sets the selected type to 88.
module sonar_datagram_deframer_top #(
  parameter int unsigned COUNT_BITS = sdd_pkg::CountBitsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  sdd_byte_if.sink byte_in,
  sdd_label_if.source label_out
);

  // Handshake between the stages: the held byte moves on whenever the
  // result register is empty or its current request is being taken.
  logic held_valid;
  logic [7:0] held_byte;
  logic can_take;
  logic fire;
  sdd_pkg::result_t res;

  assign fire = held_valid && can_take;

  // Input register: holds the byte being labelled. Its ready follows the
  // result side combinationally, so a full pipeline stalls the source at once.
  sdd_in_reg u_in_reg (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .take(can_take),
    .held_valid(held_valid),
    .held_byte(held_byte)
  );

  // Parser state and labelling. The state advances only when a byte
  // actually moves into the result register, so stalls never lose or repeat one.
  sdd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .fire(fire),
    .data_byte(held_byte),
    .res(res)
  );

  // Result register: holds a finished label while the sink is stalled.
  sdd_out_reg u_out_reg (
    .clk(clk),
    .rst(rst),
    .load_valid(held_valid),
    .res(res),
    .can_take(can_take),
    .label_out(label_out)
  );

endmodule

// ----- src/sdd_checker.sv -----
module sdd_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] byte_kind,
  input logic is_selected,
  input logic first_body,
  input logic last_of_record,
  input logic start_ok,
  input logic end_ok,
  input logic [sdd_pkg::CountWidth-1:0] record_count
);

  // A stalled result keeps its count.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(record_count))
    else $error("stalled result changed");

  a_len_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == sdd_pkg::KIND_LEN |->
      !is_selected && !first_body && !start_ok && !end_ok && !last_of_record)
    else $error("flag set on a length byte");

  a_end_ok_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_ok |-> last_of_record && byte_kind == sdd_pkg::KIND_BODY)
    else $error("end check outside the last body byte");

  a_first_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_body |-> byte_kind == sdd_pkg::KIND_BODY)
    else $error("first body marker on a header byte");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sonar_datagram_deframer_top sdd_checker u_sdd_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(label_out.valid),
  .out_ready(label_out.ready),
  .byte_kind(label_out.byte_kind),
  .is_selected(label_out.is_selected),
  .first_body(label_out.first_body),
  .last_of_record(label_out.last_of_record),
  .start_ok(label_out.start_ok),
  .end_ok(label_out.end_ok),
  .record_count(label_out.record_count)
);
